// ===== rtl/m8ie_pkg.sv =====
// Package for the 8-bit MCU instruction execute block.
// Holds opcode codes, flag bit positions, reset values and the state/item/result types.
// No dependencies.
package m8ie_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned PC_W   = 16;
   localparam int unsigned FLAG_W = 5;
   localparam int unsigned CYC_W  = 3;

   // flag bit positions
   localparam int unsigned FLAG_H = 4;
   localparam int unsigned FLAG_I = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_C = 0;

   localparam logic [FLAG_W-1:0] FLAGS_RESET = 5'b01000;
   localparam logic [DATA_W-1:0] SP_RESET    = 8'hFF;

   // opcode groups (upper nibble) for the bit ops
   localparam logic [3:0] GRP_BRSET_BRCLR = 4'h0;
   localparam logic [3:0] GRP_BSET_BCLR   = 4'h1;

   // single opcodes
   localparam logic [7:0] OP_MUL  = 8'h42;
   localparam logic [7:0] OP_STOP = 8'h8E;
   localparam logic [7:0] OP_WAIT = 8'h8F;
   localparam logic [7:0] OP_TAX  = 8'h97;
   localparam logic [7:0] OP_CLC  = 8'h98;
   localparam logic [7:0] OP_SEC  = 8'h99;
   localparam logic [7:0] OP_CLI  = 8'h9A;
   localparam logic [7:0] OP_SEI  = 8'h9B;
   localparam logic [7:0] OP_RSP  = 8'h9C;
   localparam logic [7:0] OP_NOP  = 8'h9D;
   localparam logic [7:0] OP_TXA  = 8'h9F;
   localparam logic [7:0] OP_SUB  = 8'hA0;
   localparam logic [7:0] OP_CMP  = 8'hA1;
   localparam logic [7:0] OP_SBC  = 8'hA2;
   localparam logic [7:0] OP_CPX  = 8'hA3;
   localparam logic [7:0] OP_AND  = 8'hA4;
   localparam logic [7:0] OP_BIT  = 8'hA5;
   localparam logic [7:0] OP_LDA  = 8'hA6;
   localparam logic [7:0] OP_EOR  = 8'hA8;
   localparam logic [7:0] OP_ADC  = 8'hA9;
   localparam logic [7:0] OP_ORA  = 8'hAA;
   localparam logic [7:0] OP_ADD  = 8'hAB;
   localparam logic [7:0] OP_LDX  = 8'hAE;

   // reported cycle counts
   localparam logic [CYC_W-1:0] CYC_NONE  = 3'd0;
   localparam logic [CYC_W-1:0] CYC_MUL   = 3'd1;
   localparam logic [CYC_W-1:0] CYC_BASIC = 3'd2;
   localparam logic [CYC_W-1:0] CYC_BITOP = 3'd5;

   // instruction lengths
   localparam logic [1:0] LEN_INHERENT = 2'd1;
   localparam logic [1:0] LEN_IMM      = 2'd2;
   localparam logic [1:0] LEN_BRANCH   = 2'd3;

   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 72;

   typedef struct packed {
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] index_reg;
      logic [FLAG_W-1:0] flags;
      logic [PC_W-1:0]   pc;
      logic [DATA_W-1:0] sp;
      logic              halted;
   } cpu_state_type;

   typedef struct packed {
      logic [DATA_W-1:0]        mem_data;
      logic signed [DATA_W-1:0] branch_offset;
      logic [DATA_W-1:0]        operand;
      logic [DATA_W-1:0]        opcode;
   } item_type;

   typedef struct packed {
      logic              write_enable;
      logic [DATA_W-1:0] write_addr;
      logic [DATA_W-1:0] write_data;
      logic              illegal;
      logic [CYC_W-1:0]  cycles_used;
   } side_type;

endpackage

// ===== rtl/mcu8_instruction_execute.sv =====
// Top level of the 8-bit MCU instruction execute block.
// Depends on m8ie_pkg and m8ie_execute.
//
// One decoded instruction per word on the req_ channel (opcode, operand,
// branch offset, direct-page byte); one result word per instruction on the
// rsp_ channel with the register file after the step, an optional memory
// write (BSET/BCLR), the illegal flag, the halted flag and the cycle count.
// Path: input register -> execute logic -> result register -> rsp_.
// Throughput: one instruction per cycle while rsp_ is not stalled; the
// input register feeds the execute logic, whose result and next state are
// captured together, so the only loop is state -> execute -> state.
// When rsp_tready is low the result register holds, the input register
// keeps one more word, and req_tready drops once both are full.
// Reset (synchronous, active high) empties both stages and loads
// A = X = 0, flags = I only, PC = 0, SP = 0xFF, not halted.
// After STOP or WAIT every later word is answered with the unchanged state.
module mcu8_instruction_execute (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] opcode, [15:8] operand, [23:16] branch_offset, [31:24] mem_data
   input  logic [m8ie_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] acc_out, [15:8] index_out, [20:16] flags_out, [36:21] pc_out,
   // [44:37] sp_out, [45] write_enable, [53:46] write_addr, [61:54] write_data,
   // [62] illegal, [63] halted_out, [66:64] cycles_used, [71:67] zero
   output logic [m8ie_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic                    in_valid_ff;
   m8ie_pkg::item_type      in_item_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   m8ie_pkg::cpu_state_type state_ff;
   m8ie_pkg::cpu_state_type state_in;
   m8ie_pkg::side_type      side_ff;
   m8ie_pkg::side_type      side_in;
   logic                    advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   m8ie_execute u_execute (
      .cur  (state_ff),
      .item (in_item_ff),
      .nxt  (state_in),
      .side (side_in)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.acc       <= 8'd0;
         state_ff.index_reg <= 8'd0;
         state_ff.flags     <= m8ie_pkg::FLAGS_RESET;
         state_ff.pc        <= 16'd0;
         state_ff.sp        <= m8ie_pkg::SP_RESET;
         state_ff.halted    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= m8ie_pkg::item_type'(req_tdata);
      end
      if (advance) begin
         side_ff <= side_in;
      end
   end

   // state_ff already holds the post-instruction state of the word in side_ff
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0,
                        side_ff.cycles_used,
                        state_ff.halted,
                        side_ff.illegal,
                        side_ff.write_data,
                        side_ff.write_addr,
                        side_ff.write_enable,
                        state_ff.sp,
                        state_ff.pc,
                        state_ff.flags,
                        state_ff.index_reg,
                        state_ff.acc};

`ifndef SYNTH
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.halted |=> state_ff.halted)
      else $error("halted flag cleared without reset");

   a_write_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && side_ff.write_enable) |-> (!side_ff.illegal &&
         side_ff.cycles_used == m8ie_pkg::CYC_BITOP))
      else $error("memory write on a non bit-op result");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |=>
         (in_valid_ff && out_valid_ff))
      else $error("stalled word lost from the input register");
`endif

endmodule

// ===== rtl/m8ie_execute.sv =====
// Combinational instruction step: current state plus one item -> next state and side outputs.
// Uses m8ie_pkg for types, opcodes and flag positions.
module m8ie_execute (
   input  m8ie_pkg::cpu_state_type cur,
   input  m8ie_pkg::item_type      item,
   output m8ie_pkg::cpu_state_type nxt,
   output m8ie_pkg::side_type      side
);

   logic [7:0]  op;
   logic [7:0]  opd;
   logic [7:0]  bit_mask;
   logic        bit_set;
   logic        taken;
   logic [1:0]  len;
   logic [15:0] mul_p;
   logic [8:0]  sub_r;
   logic [7:0]  sub_b;
   logic        sub_borrow;
   logic [8:0]  add_r;
   logic [4:0]  add_h;
   logic        add_cin;
   logic [7:0]  logic_r;
   logic        carry;

   always_comb begin
      op         = item.opcode;
      opd        = item.operand;
      bit_mask   = 8'(8'd1 << op[3:1]);
      bit_set    = (item.mem_data & bit_mask) != 8'd0;
      taken      = op[0] ? !bit_set : bit_set;
      carry      = cur.flags[m8ie_pkg::FLAG_C];
      mul_p      = {8'd0, cur.acc} * {8'd0, cur.index_reg};
      sub_b      = (op == m8ie_pkg::OP_CPX) ? cur.index_reg : cur.acc;
      sub_borrow = (op == m8ie_pkg::OP_SBC) ? carry : 1'b0;
      sub_r      = {1'b0, sub_b} - {1'b0, opd} - {8'd0, sub_borrow};
      add_cin    = (op == m8ie_pkg::OP_ADC) ? carry : 1'b0;
      add_r      = {1'b0, cur.acc} + {1'b0, opd} + {8'd0, add_cin};
      add_h      = {1'b0, cur.acc[3:0]} + {1'b0, opd[3:0]} + {4'd0, add_cin};
      logic_r    = 8'd0;
      len        = m8ie_pkg::LEN_INHERENT;

      nxt               = cur;
      side.write_enable = 1'b0;
      side.write_addr   = 8'd0;
      side.write_data   = 8'd0;
      side.illegal      = 1'b0;
      side.cycles_used  = m8ie_pkg::CYC_NONE;

      if (!cur.halted) begin
         side.cycles_used = m8ie_pkg::CYC_BASIC;
         if (op[7:4] == m8ie_pkg::GRP_BRSET_BRCLR) begin
            side.cycles_used = m8ie_pkg::CYC_BITOP;
            nxt.flags[m8ie_pkg::FLAG_C] = bit_set;
            len = m8ie_pkg::LEN_BRANCH;
         end else if (op[7:4] == m8ie_pkg::GRP_BSET_BCLR) begin
            side.cycles_used  = m8ie_pkg::CYC_BITOP;
            side.write_enable = 1'b1;
            side.write_addr   = opd;
            side.write_data   = op[0] ? (item.mem_data & ~bit_mask)
                                      : (item.mem_data | bit_mask);
            len = m8ie_pkg::LEN_IMM;
         end else begin
            unique case (op) inside
               m8ie_pkg::OP_MUL: begin
                  nxt.index_reg = mul_p[15:8];
                  nxt.acc       = mul_p[7:0];
                  nxt.flags[m8ie_pkg::FLAG_H] = 1'b0;
                  nxt.flags[m8ie_pkg::FLAG_C] = 1'b0;
                  side.cycles_used = m8ie_pkg::CYC_MUL;
               end
               m8ie_pkg::OP_STOP, m8ie_pkg::OP_WAIT: begin
                  nxt.halted = 1'b1;
                  nxt.flags[m8ie_pkg::FLAG_I] = 1'b0;
               end
               m8ie_pkg::OP_TAX: nxt.index_reg = cur.acc;
               m8ie_pkg::OP_CLC: nxt.flags[m8ie_pkg::FLAG_C] = 1'b0;
               m8ie_pkg::OP_SEC: nxt.flags[m8ie_pkg::FLAG_C] = 1'b1;
               m8ie_pkg::OP_CLI: nxt.flags[m8ie_pkg::FLAG_I] = 1'b0;
               m8ie_pkg::OP_SEI: nxt.flags[m8ie_pkg::FLAG_I] = 1'b1;
               m8ie_pkg::OP_RSP: nxt.sp = m8ie_pkg::SP_RESET;
               m8ie_pkg::OP_NOP: ;
               m8ie_pkg::OP_TXA: nxt.acc = cur.index_reg;
               m8ie_pkg::OP_SUB, m8ie_pkg::OP_CMP, m8ie_pkg::OP_SBC, m8ie_pkg::OP_CPX: begin
                  len = m8ie_pkg::LEN_IMM;
                  if (op == m8ie_pkg::OP_SUB || op == m8ie_pkg::OP_SBC) begin
                     nxt.acc = sub_r[7:0];
                  end
                  nxt.flags[m8ie_pkg::FLAG_N] = sub_r[7];
                  nxt.flags[m8ie_pkg::FLAG_Z] = sub_r[7:0] == 8'd0;
                  nxt.flags[m8ie_pkg::FLAG_C] = sub_r[8];
               end
               m8ie_pkg::OP_ADC, m8ie_pkg::OP_ADD: begin
                  len = m8ie_pkg::LEN_IMM;
                  nxt.acc = add_r[7:0];
                  nxt.flags[m8ie_pkg::FLAG_H] = add_h[4];
                  nxt.flags[m8ie_pkg::FLAG_N] = add_r[7];
                  nxt.flags[m8ie_pkg::FLAG_Z] = add_r[7:0] == 8'd0;
                  nxt.flags[m8ie_pkg::FLAG_C] = add_r[8];
               end
               m8ie_pkg::OP_AND, m8ie_pkg::OP_BIT, m8ie_pkg::OP_LDA, m8ie_pkg::OP_EOR,
               m8ie_pkg::OP_ORA, m8ie_pkg::OP_LDX: begin
                  len = m8ie_pkg::LEN_IMM;
                  case (op)
                     m8ie_pkg::OP_AND: logic_r = cur.acc & opd;
                     m8ie_pkg::OP_BIT: logic_r = cur.acc & opd;
                     m8ie_pkg::OP_EOR: logic_r = cur.acc ^ opd;
                     m8ie_pkg::OP_ORA: logic_r = cur.acc | opd;
                     default:          logic_r = opd;
                  endcase
                  if (op == m8ie_pkg::OP_LDX) begin
                     nxt.index_reg = logic_r;
                  end else if (op != m8ie_pkg::OP_BIT) begin
                     nxt.acc = logic_r;
                  end
                  nxt.flags[m8ie_pkg::FLAG_N] = logic_r[7];
                  nxt.flags[m8ie_pkg::FLAG_Z] = logic_r == 8'd0;
               end
               default: begin
                  // everything outside the subset: only the PC moves
                  side.illegal     = 1'b1;
                  side.cycles_used = m8ie_pkg::CYC_NONE;
               end
            endcase
         end

         if (op[7:4] == m8ie_pkg::GRP_BRSET_BRCLR && taken) begin
            nxt.pc = cur.pc + 16'd3 + {{8{item.branch_offset[7]}}, item.branch_offset};
         end else begin
            nxt.pc = cur.pc + {14'd0, len};
         end
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for mcu8_instruction_execute: directed and random
// instruction streams, checked against a cycle-free model of the core state.
// Depends on m8ie_pkg and the mcu8_instruction_execute RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]  acc;
      logic [7:0]  index_reg;
      logic [4:0]  flags;
      logic [15:0] pc;
      logic [7:0]  sp;
      logic        write_enable;
      logic [7:0]  write_addr;
      logic [7:0]  write_data;
      logic        illegal;
      logic        halted;
      logic [2:0]  cycles;
   } exec_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   // core state as the testbench sees it
   logic [7:0]  st_acc;
   logic [7:0]  st_x;
   logic [4:0]  st_flags;
   logic [15:0] st_pc;
   logic [7:0]  st_sp;
   logic        st_halted;

   exec_result_type pending_results[$];
   logic [7:0]      legal_ops[$] = '{
      m8ie_pkg::OP_MUL, m8ie_pkg::OP_TAX, m8ie_pkg::OP_CLC, m8ie_pkg::OP_SEC,
      m8ie_pkg::OP_CLI, m8ie_pkg::OP_SEI, m8ie_pkg::OP_RSP, m8ie_pkg::OP_NOP,
      m8ie_pkg::OP_TXA, m8ie_pkg::OP_SUB, m8ie_pkg::OP_CMP, m8ie_pkg::OP_SBC,
      m8ie_pkg::OP_CPX, m8ie_pkg::OP_AND, m8ie_pkg::OP_BIT, m8ie_pkg::OP_LDA,
      m8ie_pkg::OP_EOR, m8ie_pkg::OP_ADC, m8ie_pkg::OP_ORA, m8ie_pkg::OP_ADD,
      m8ie_pkg::OP_LDX};

   int unsigned send_idle_pct = 32;
   int unsigned recv_idle_pct = 48;
   int unsigned hold_off_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned illegal_seen = 0;
   int unsigned writes_seen = 0;

   mcu8_instruction_execute u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic void update_nz(logic [7:0] v);
      st_flags[m8ie_pkg::FLAG_N] = v[7];
      st_flags[m8ie_pkg::FLAG_Z] = (v == 8'h00);
   endfunction

   function automatic logic [7:0] sub8(logic [7:0] a, logic [7:0] b, logic cin);
      logic [8:0] wide;
      wide = {1'b0, a} - {1'b0, b} - {8'd0, cin};
      update_nz(wide[7:0]);
      st_flags[m8ie_pkg::FLAG_C] = wide[8];
      return wide[7:0];
   endfunction

   function automatic logic [7:0] add8(logic [7:0] a, logic [7:0] b, logic cin);
      logic [8:0] wide;
      logic [4:0] nib;
      wide = {1'b0, a} + {1'b0, b} + {8'd0, cin};
      nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
      st_flags[m8ie_pkg::FLAG_H] = nib[4];
      update_nz(wide[7:0]);
      st_flags[m8ie_pkg::FLAG_C] = wide[8];
      return wide[7:0];
   endfunction

   function automatic exec_result_type execute_instr(m8ie_pkg::item_type it);
      exec_result_type r;
      logic [7:0]   bit_mask;
      logic [15:0]  advance;
      logic [15:0]  product;
      logic         c_in;
      logic         bit_set;
      logic         taken;
      r = '{default: '0};
      if (!st_halted) begin
         bit_mask = 8'h01 << it.opcode[3:1];
         c_in     = st_flags[m8ie_pkg::FLAG_C];
         advance  = 16'(m8ie_pkg::LEN_INHERENT);
         r.cycles = m8ie_pkg::CYC_BASIC;
         if (it.opcode[7:4] == m8ie_pkg::GRP_BRSET_BRCLR) begin
            bit_set = (it.mem_data & bit_mask) != 8'h00;
            taken   = it.opcode[0] ? !bit_set : bit_set;
            st_flags[m8ie_pkg::FLAG_C] = bit_set;
            r.cycles = m8ie_pkg::CYC_BITOP;
            advance  = 16'(m8ie_pkg::LEN_BRANCH);
            if (taken)
               advance = advance + {{8{it.branch_offset[7]}}, it.branch_offset};
         end else if (it.opcode[7:4] == m8ie_pkg::GRP_BSET_BCLR) begin
            advance        = 16'(m8ie_pkg::LEN_IMM);
            r.cycles       = m8ie_pkg::CYC_BITOP;
            r.write_enable = 1'b1;
            r.write_addr   = it.operand;
            r.write_data   = it.opcode[0] ? (it.mem_data & ~bit_mask)
                                          : (it.mem_data | bit_mask);
         end else begin
            case (it.opcode)
               m8ie_pkg::OP_MUL: begin
                  product = 16'(st_acc) * 16'(st_x);
                  {st_x, st_acc} = product;
                  st_flags[m8ie_pkg::FLAG_H] = 1'b0;
                  st_flags[m8ie_pkg::FLAG_C] = 1'b0;
                  r.cycles = m8ie_pkg::CYC_MUL;
               end
               m8ie_pkg::OP_STOP, m8ie_pkg::OP_WAIT: begin
                  st_halted = 1'b1;
                  st_flags[m8ie_pkg::FLAG_I] = 1'b0;
               end
               m8ie_pkg::OP_TAX: st_x = st_acc;
               m8ie_pkg::OP_CLC: st_flags[m8ie_pkg::FLAG_C] = 1'b0;
               m8ie_pkg::OP_SEC: st_flags[m8ie_pkg::FLAG_C] = 1'b1;
               m8ie_pkg::OP_CLI: st_flags[m8ie_pkg::FLAG_I] = 1'b0;
               m8ie_pkg::OP_SEI: st_flags[m8ie_pkg::FLAG_I] = 1'b1;
               m8ie_pkg::OP_RSP: st_sp = m8ie_pkg::SP_RESET;
               m8ie_pkg::OP_NOP: ;
               m8ie_pkg::OP_TXA: st_acc = st_x;
               m8ie_pkg::OP_SUB: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_acc = sub8(st_acc, it.operand, 1'b0);
               end
               m8ie_pkg::OP_CMP: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  void'(sub8(st_acc, it.operand, 1'b0));
               end
               m8ie_pkg::OP_SBC: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_acc = sub8(st_acc, it.operand, c_in);
               end
               m8ie_pkg::OP_CPX: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  void'(sub8(st_x, it.operand, 1'b0));
               end
               m8ie_pkg::OP_AND: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_acc = st_acc & it.operand;
                  update_nz(st_acc);
               end
               m8ie_pkg::OP_BIT: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  update_nz(st_acc & it.operand);
               end
               m8ie_pkg::OP_LDA: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_acc = it.operand;
                  update_nz(st_acc);
               end
               m8ie_pkg::OP_EOR: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_acc = st_acc ^ it.operand;
                  update_nz(st_acc);
               end
               m8ie_pkg::OP_ADC: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_acc = add8(st_acc, it.operand, c_in);
               end
               m8ie_pkg::OP_ORA: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_acc = st_acc | it.operand;
                  update_nz(st_acc);
               end
               m8ie_pkg::OP_ADD: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_acc = add8(st_acc, it.operand, 1'b0);
               end
               m8ie_pkg::OP_LDX: begin
                  advance = 16'(m8ie_pkg::LEN_IMM);
                  st_x = it.operand;
                  update_nz(st_x);
               end
               default: begin
                  r.illegal = 1'b1;
                  r.cycles  = m8ie_pkg::CYC_NONE;
               end
            endcase
         end
         st_pc = st_pc + advance;
      end
      r.acc       = st_acc;
      r.index_reg = st_x;
      r.flags     = st_flags;
      r.pc        = st_pc;
      r.sp        = st_sp;
      r.halted    = st_halted;
      return r;
   endfunction

   // ------------------------------------------------------------ stimulus

   function automatic m8ie_pkg::item_type make_instr(logic [7:0] op, logic [7:0] opd,
                                                     logic [7:0] off, logic [7:0] mem);
      m8ie_pkg::item_type it;
      it.opcode        = op;
      it.operand       = opd;
      it.branch_offset = off;
      it.mem_data      = mem;
      return it;
   endfunction

   function automatic logic [7:0] random_byte();
      logic [7:0] corners[5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
      if ($urandom_range(99) < 20)
         return corners[$urandom_range(4)];
      return 8'($urandom_range(255));
   endfunction

   // halt opcodes are kept out: they would freeze the core for the rest of the run
   function automatic m8ie_pkg::item_type random_instr();
      logic [7:0]  op;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 45)
         op = legal_ops[$urandom_range(legal_ops.size() - 1)];
      else if (pick < 70)
         op = 8'($urandom_range(8'h1F));
      else begin
         do op = 8'($urandom_range(255));
         while (op == m8ie_pkg::OP_STOP || op == m8ie_pkg::OP_WAIT);
      end
      return make_instr(op, random_byte(), random_byte(), random_byte());
   endfunction

   task automatic send_instr(m8ie_pkg::item_type it);
      exec_result_type r;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it;
      do @(posedge clock); while (!req_tready);
      r = execute_instr(it);
      pending_results.push_back(r);
      words_sent++;
      if (r.illegal) illegal_seen++;
      if (r.write_enable) writes_seen++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // --------------------------------------------------------------- tests

   task automatic test_alu_immediate();
      send_instr(make_instr(m8ie_pkg::OP_LDA, 8'hFF, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_ADD, 8'h01, 8'h00, 8'h00));   // wraps to zero, C and H
      send_instr(make_instr(m8ie_pkg::OP_ADC, 8'h7F, 8'h00, 8'h00));   // carry in
      send_instr(make_instr(m8ie_pkg::OP_SUB, 8'h80, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_SBC, 8'h01, 8'h00, 8'h00));   // borrow out
      send_instr(make_instr(m8ie_pkg::OP_CMP, 8'hFF, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_LDX, 8'h80, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_CPX, 8'h7F, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_AND, 8'h0F, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_BIT, 8'hF0, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_EOR, 8'hFF, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_ORA, 8'h00, 8'h00, 8'h00));
      wait_for_drain();
   endtask

   task automatic test_inherent_ops();
      send_instr(make_instr(m8ie_pkg::OP_LDA, 8'hFF, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_TAX, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_MUL, 8'h00, 8'h00, 8'h00));   // FF * FF
      send_instr(make_instr(m8ie_pkg::OP_TXA, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_SEC, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_CLC, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_CLI, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_SEI, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_RSP, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_NOP, 8'h00, 8'h00, 8'h00));
      wait_for_drain();
   endtask

   task automatic test_bit_ops();
      // taken backwards branch near zero wraps the PC below 0
      send_instr(make_instr(8'h00, 8'h10, 8'h80, 8'h01));
      send_instr(make_instr(8'h0F, 8'hFF, 8'h7F, 8'h7F));    // BRCLR 7, taken forward
      send_instr(make_instr(8'h1E, 8'hFF, 8'h00, 8'h00));    // BSET 7
      send_instr(make_instr(8'h11, 8'h00, 8'h00, 8'hFF));    // BCLR 0
      wait_for_drain();
   endtask

   task automatic test_illegal_ops();
      send_instr(make_instr(8'h20, 8'hAA, 8'h55, 8'h00));
      send_instr(make_instr(8'hFF, 8'h55, 8'hAA, 8'hFF));
      wait_for_drain();
   endtask

   task automatic test_random_stream(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int unsigned i = 0; i < count; i++) begin
         send_instr(random_instr());
         if (i == count / 2) wait_for_drain();
      end
      wait_for_drain();
   endtask

   // receiver stalls long enough for both stages to fill and block the input
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_left = 60;
      for (int unsigned i = 0; i < 40; i++)
         send_instr(random_instr());
      wait_for_drain();
   endtask

   task automatic test_halt();
      logic [7:0] halt_op;
      logic [7:0] other_op;
      halt_op  = $urandom_range(1) ? m8ie_pkg::OP_WAIT : m8ie_pkg::OP_STOP;
      other_op = (halt_op == m8ie_pkg::OP_WAIT) ? m8ie_pkg::OP_STOP : m8ie_pkg::OP_WAIT;
      send_idle_pct = 32;
      recv_idle_pct = 48;
      send_instr(make_instr(halt_op, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(other_op, 8'h00, 8'h00, 8'h00));
      send_instr(make_instr(8'h1E, 8'h12, 8'h00, 8'h00));
      send_instr(make_instr(m8ie_pkg::OP_LDA, 8'h34, 8'h00, 8'h00));
      send_instr(make_instr(8'h33, 8'h00, 8'h00, 8'h00));
      wait_for_drain();
   endtask

   // ------------------------------------------------------------ checking

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      exec_result_type want;
      exec_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.acc          = rsp_tdata[7:0];
         got.index_reg    = rsp_tdata[15:8];
         got.flags        = rsp_tdata[20:16];
         got.pc           = rsp_tdata[36:21];
         got.sp           = rsp_tdata[44:37];
         got.write_enable = rsp_tdata[45];
         got.write_addr   = rsp_tdata[53:46];
         got.write_data   = rsp_tdata[61:54];
         got.illegal      = rsp_tdata[62];
         got.halted       = rsp_tdata[63];
         got.cycles       = rsp_tdata[66:64];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result word with nothing outstanding: %h", $realtime, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            words_checked++;
            check_field("acc_out", 16'(want.acc), 16'(got.acc));
            check_field("index_out", 16'(want.index_reg), 16'(got.index_reg));
            check_field("flags_out", 16'(want.flags), 16'(got.flags));
            check_field("pc_out", want.pc, got.pc);
            check_field("sp_out", 16'(want.sp), 16'(got.sp));
            check_field("write_enable", 16'(want.write_enable), 16'(got.write_enable));
            check_field("write_addr", 16'(want.write_addr), 16'(got.write_addr));
            check_field("write_data", 16'(want.write_data), 16'(got.write_data));
            check_field("illegal", 16'(want.illegal), 16'(got.illegal));
            check_field("halted_out", 16'(want.halted), 16'(got.halted));
            check_field("cycles_used", 16'(want.cycles), 16'(got.cycles));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // --------------------------------------------------------------- main

   initial begin
      st_acc    = 8'h00;
      st_x      = 8'h00;
      st_flags  = m8ie_pkg::FLAGS_RESET;
      st_pc     = 16'h0000;
      st_sp     = m8ie_pkg::SP_RESET;
      st_halted = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_alu_immediate();
      test_inherent_ops();
      test_bit_ops();
      test_illegal_ops();
      test_random_stream(32, 48, 340);
      test_random_stream(48, 32, 340);
      test_random_stream(0, 0, 340);
      test_backpressure();
      test_halt();

      repeat (6) @(posedge clock);
      $display("Sent %0d instruction words (%0d illegal, %0d memory writes), checked %0d results,",
               words_sent, illegal_seen, writes_seen, words_checked);
      $display("under random stalls on both sides, a long receiver hold-off and a final halt.");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/m8ie_pkg.sv
rtl/m8ie_execute.sv
rtl/mcu8_instruction_execute.sv
sim/tb_top.sv
